// ----- src/watnm_pkg.sv -----
// ----------------------------------------------------------------------------
// watnm_pkg
// Shared types and constants of the weekly alarm table: commands, table
// entry layout, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package watnm_pkg;

    localparam int COUNT_W    = 4;
    localparam int HOUR_W     = 5;
    localparam int MINUTE_W   = 6;
    localparam int DAYS_W     = 8;
    localparam int WEEKDAY_W  = 3;
    localparam int KEY_W      = 11;

    localparam logic [HOUR_W-1:0]    MAX_HOUR   = 5'd23;
    localparam logic [MINUTE_W-1:0]  MAX_MINUTE = 6'd59;
    localparam logic [WEEKDAY_W-1:0] WEEK_DAYS  = 3'd7;

    typedef enum logic [1:0] {
        CMD_PUT    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_NEXT   = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic [DAYS_W-1:0]   days;
        logic                enabled;
    } alarm_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PUT,
        S_RM_CHK,
        S_RM_RD,
        S_RM_WR,
        S_RD_ADDR,
        S_NX_RD,
        S_NX_EV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic prime;
        logic put_write;
        logic rm_read;
        logic rm_write;
        logic rm_dec;
        logic rd_slot;
        logic scan_read;
        logic scan_eval;
        logic load_out;
    } dp_ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic slot_ok;
        logic shift_more;
        logic scan_more;
        logic count_zero;
    } dp_stat_t;

endpackage

// ----- src/weekly_alarm_table_next_match.sv -----
// ----------------------------------------------------------------------------
// weekly_alarm_table_next_match
// Weekly alarm table with put, remove, read and next-alarm search.
// ----------------------------------------------------------------------------
// One command per beat, one result beat per command. The table sits in a
// memory with a registered read: put decodes and writes, read decodes and
// fetches the slot, remove decodes, then checks, reads and writes once per
// entry moved up to close the gap, and next decodes, then reads and evaluates
// each held entry in turn. A new command is taken once the previous result
// is in the output register, even while that result waits to be taken.
// entry_count gives the number of entries held once the command has finished.
module weekly_alarm_table_next_match
    import watnm_pkg::*;
#(
    parameter int MAX_ALARMS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic [COUNT_W-1:0]    slot,
    input  logic [HOUR_W-1:0]     entry_hour,
    input  logic [MINUTE_W-1:0]   entry_minute,
    input  logic [DAYS_W-1:0]     entry_days,
    input  logic                  entry_enabled,
    input  logic [WEEKDAY_W-1:0]  now_weekday,
    input  logic [HOUR_W-1:0]     now_hour,
    input  logic [MINUTE_W-1:0]   now_minute,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  status,
    output logic [COUNT_W-1:0]    entry_count,
    output logic                  found,
    output logic [2:0]            days_ahead,
    output logic [HOUR_W-1:0]     out_hour,
    output logic [MINUTE_W-1:0]   out_minute,
    output logic [DAYS_W-1:0]     out_days,
    output logic                  out_enabled
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    watnm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    watnm_dp #(
        .MAX_ALARMS (MAX_ALARMS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .cmd           (cmd),
        .slot          (slot),
        .entry_hour    (entry_hour),
        .entry_minute  (entry_minute),
        .entry_days    (entry_days),
        .entry_enabled (entry_enabled),
        .now_weekday   (now_weekday),
        .now_hour      (now_hour),
        .now_minute    (now_minute),
        .status        (status),
        .entry_count   (entry_count),
        .found         (found),
        .days_ahead    (days_ahead),
        .out_hour      (out_hour),
        .out_minute    (out_minute),
        .out_days      (out_days),
        .out_enabled   (out_enabled)
    );

endmodule

// ----- src/watnm_ctrl.sv -----
// ----------------------------------------------------------------------------
// watnm_ctrl
// Command sequencer: accepts a beat, steps the datapath through put,
// remove, read or next, and hands the result to the output register.
// ----------------------------------------------------------------------------
module watnm_ctrl
    import watnm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.cmd)
                    CMD_PUT:    state_next = S_PUT;
                    CMD_REMOVE: state_next = stat.slot_ok ? S_RM_CHK : S_DONE;
                    CMD_READ:   state_next = stat.slot_ok ? S_RD_ADDR : S_DONE;
                    CMD_NEXT:   state_next = stat.count_zero ? S_DONE : S_NX_RD;
                    default:    state_next = S_DONE;
                endcase
            end
            S_PUT:     state_next = S_DONE;
            S_RM_CHK:  state_next = stat.shift_more ? S_RM_RD : S_DONE;
            S_RM_RD:   state_next = S_RM_WR;
            S_RM_WR:   state_next = S_RM_CHK;
            S_RD_ADDR: state_next = S_DONE;
            S_NX_RD:   state_next = S_NX_EV;
            S_NX_EV:   state_next = stat.scan_more ? S_NX_RD : S_DONE;
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl     = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.load_in = in_valid;
            end
            S_DECODE:  ctrl.prime     = 1'b1;
            S_PUT:     ctrl.put_write = 1'b1;
            S_RM_CHK:  ctrl.rm_dec    = !stat.shift_more;
            S_RM_RD:   ctrl.rm_read   = 1'b1;
            S_RM_WR:   ctrl.rm_write  = 1'b1;
            S_RD_ADDR: ctrl.rd_slot   = 1'b1;
            S_NX_RD:   ctrl.scan_read = 1'b1;
            S_NX_EV:   ctrl.scan_eval = 1'b1;
            S_DONE:    ctrl.load_out  = !out_valid_reg || out_ready;
            default:   ctrl           = '0;
        endcase
    end

    always_comb
    begin
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken beat");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted beat not decoded");

endmodule

// ----- src/watnm_dp.sv -----
// ----------------------------------------------------------------------------
// watnm_dp
// Datapath: command registers, alarm table memory, entry count, next-match
// evaluation of one entry per step, and the result register.
// ----------------------------------------------------------------------------
module watnm_dp
    import watnm_pkg::*;
#(
    parameter int MAX_ALARMS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_ctrl_t              ctrl,
    output dp_stat_t              stat,
    input  logic [1:0]            cmd,
    input  logic [COUNT_W-1:0]    slot,
    input  logic [HOUR_W-1:0]     entry_hour,
    input  logic [MINUTE_W-1:0]   entry_minute,
    input  logic [DAYS_W-1:0]     entry_days,
    input  logic                  entry_enabled,
    input  logic [WEEKDAY_W-1:0]  now_weekday,
    input  logic [HOUR_W-1:0]     now_hour,
    input  logic [MINUTE_W-1:0]   now_minute,
    output logic                  status,
    output logic [COUNT_W-1:0]    entry_count,
    output logic                  found,
    output logic [2:0]            days_ahead,
    output logic [HOUR_W-1:0]     out_hour,
    output logic [MINUTE_W-1:0]   out_minute,
    output logic [DAYS_W-1:0]     out_days,
    output logic                  out_enabled
);

    localparam int IDX_W = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_ALARMS);

    function automatic logic [KEY_W-1:0] time_key(
        input logic [HOUR_W-1:0]   h,
        input logic [MINUTE_W-1:0] m
    );
        time_key = {h, 6'd0} - {4'd0, h, 2'd0} + {5'd0, m};
    endfunction

    function automatic logic [6:0] rotate_days(
        input logic [6:0]           days,
        input logic [WEEKDAY_W-1:0] wd
    );
        logic [3:0] pos;
        logic [6:0] r;
        r = '0;
        for (int k = 0; k < 7; k++)
        begin
            pos = {1'b0, wd} + 4'(k);
            if (pos >= {1'b0, WEEK_DAYS})
            begin
                pos = pos - {1'b0, WEEK_DAYS};
            end
            r[k] = days[pos[2:0]];
        end
        rotate_days = r;
    endfunction

    function automatic logic [3:0] pick_day(
        input logic [6:0] r,
        input logic       later
    );
        logic       hit;
        logic [2:0] d;
        hit = 1'b0;
        d   = 3'd0;
        if (r[0] && later)
        begin
            hit = 1'b1;
        end
        else
        begin
            for (int k = 6; k >= 1; k--)
            begin
                if (r[k])
                begin
                    hit = 1'b1;
                    d   = 3'(k);
                end
            end
            if (!hit && r[0])
            begin
                hit = 1'b1;
                d   = 3'd7;
            end
        end
        pick_day = {hit, d};
    endfunction

    // command registers
    cmd_t                  cmd_reg;
    logic [COUNT_W-1:0]    slot_reg;
    alarm_t                entry_reg;
    logic [WEEKDAY_W-1:0]  now_wd_reg;
    logic [HOUR_W-1:0]     now_hour_reg;
    logic [MINUTE_W-1:0]   now_minute_reg;

    // table and control
    alarm_t                mem [MAX_ALARMS];
    alarm_t                rdata_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic                  rd_en;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    alarm_t                wr_data;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic [COUNT_W-1:0]    idx_reg;
    logic [COUNT_W-1:0]    idx_next;
    logic [COUNT_W:0]      idx_inc;
    logic                  status_reg;
    logic                  status_next;

    // search state
    logic                  found_reg;
    logic [2:0]            best_day_reg;
    logic [KEY_W-1:0]      best_tkey_reg;
    logic [HOUR_W-1:0]     best_hour_reg;
    logic [MINUTE_W-1:0]   best_minute_reg;

    // result register
    logic                  res_status_reg;
    logic [COUNT_W-1:0]    res_count_reg;
    logic                  res_found_reg;
    logic [2:0]            res_day_reg;
    logic [HOUR_W-1:0]     res_hour_reg;
    logic [MINUTE_W-1:0]   res_minute_reg;
    logic [DAYS_W-1:0]     res_days_reg;
    logic                  res_enabled_reg;

    logic                  put_args_ok;
    logic                  put_ok;
    logic                  slot_ok;
    logic [WEEKDAY_W-1:0]  nw7;
    logic [KEY_W-1:0]      now_key;
    logic [KEY_W-1:0]      cand_tkey;
    logic [3:0]            pick;
    logic                  cand_hit;
    logic                  cand_better;

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            cmd_reg           <= cmd_t'(cmd);
            slot_reg          <= slot;
            entry_reg.hour    <= entry_hour;
            entry_reg.minute  <= entry_minute;
            entry_reg.days    <= entry_days;
            entry_reg.enabled <= entry_enabled;
            now_wd_reg        <= now_weekday;
            now_hour_reg      <= now_hour;
            now_minute_reg    <= now_minute;
        end
    end

    assign put_args_ok = (entry_reg.hour <= MAX_HOUR) && (entry_reg.minute <= MAX_MINUTE)
                         && (entry_reg.days[6:0] != 7'd0);
    assign slot_ok     = slot_reg < count_reg;
    assign put_ok      = put_args_ok
                         && (slot_ok || ((slot_reg == count_reg) && (count_reg < MAX_CNT)));
    assign idx_inc     = {1'b0, idx_reg} + 5'd1;

    always_comb
    begin
        status_next = status_reg;
        if (ctrl.prime)
        begin
            case (cmd_reg) inside
                CMD_PUT:                status_next = !put_ok;
                CMD_REMOVE, CMD_READ:   status_next = !slot_ok;
                default:                status_next = 1'b0;
            endcase
        end
    end

    assign rd_en = ctrl.rm_read || ctrl.rd_slot || ctrl.scan_read;

    always_comb
    begin
        rd_addr = idx_reg[IDX_W-1:0];
        if (ctrl.rm_read)
        begin
            rd_addr = idx_inc[IDX_W-1:0];
        end
        else if (ctrl.rd_slot)
        begin
            rd_addr = slot_reg[IDX_W-1:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = rdata_reg;
        if (ctrl.put_write && !status_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = slot_reg[IDX_W-1:0];
            wr_data = entry_reg;
        end
        else if (ctrl.rm_write)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.put_write && !status_reg && (slot_reg == count_reg))
        begin
            count_next = count_reg + 4'd1;
        end
        else if (ctrl.rm_dec)
        begin
            count_next = count_reg - 4'd1;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (ctrl.prime)
        begin
            idx_next = (cmd_reg == CMD_REMOVE) ? slot_reg : '0;
        end
        else if (ctrl.rm_write || ctrl.scan_eval)
        begin
            idx_next = idx_inc[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        status_reg <= status_next;
    end

    // evaluate the entry in rdata_reg against the current time
    assign nw7       = (now_wd_reg == WEEK_DAYS) ? '0 : now_wd_reg;
    assign now_key   = time_key(now_hour_reg, now_minute_reg);
    assign cand_tkey = time_key(rdata_reg.hour, rdata_reg.minute);
    assign pick      = pick_day(rotate_days(rdata_reg.days[6:0], nw7), cand_tkey > now_key);
    assign cand_hit  = rdata_reg.enabled && pick[3];
    assign cand_better = !found_reg || ({pick[2:0], cand_tkey} < {best_day_reg, best_tkey_reg});

    always_ff @(posedge clk)
    begin
        if (ctrl.prime)
        begin
            found_reg       <= 1'b0;
            best_day_reg    <= '0;
            best_tkey_reg   <= '0;
            best_hour_reg   <= '0;
            best_minute_reg <= '0;
        end
        else if (ctrl.scan_eval && cand_hit && cand_better)
        begin
            found_reg       <= 1'b1;
            best_day_reg    <= pick[2:0];
            best_tkey_reg   <= cand_tkey;
            best_hour_reg   <= rdata_reg.hour;
            best_minute_reg <= rdata_reg.minute;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_out)
        begin
            res_status_reg  <= status_reg;
            res_count_reg   <= count_reg;
            res_found_reg   <= found_reg;
            res_day_reg     <= best_day_reg;
            res_hour_reg    <= '0;
            res_minute_reg  <= '0;
            res_days_reg    <= '0;
            res_enabled_reg <= 1'b0;
            if (cmd_reg == CMD_NEXT)
            begin
                res_hour_reg   <= best_hour_reg;
                res_minute_reg <= best_minute_reg;
            end
            else if ((cmd_reg == CMD_READ) && !status_reg)
            begin
                res_hour_reg    <= rdata_reg.hour;
                res_minute_reg  <= rdata_reg.minute;
                res_days_reg    <= rdata_reg.days;
                res_enabled_reg <= rdata_reg.enabled;
            end
        end
    end

    assign stat.cmd        = cmd_reg;
    assign stat.slot_ok    = slot_ok;
    assign stat.shift_more = idx_inc < {1'b0, count_reg};
    assign stat.scan_more  = idx_inc < {1'b0, count_reg};
    assign stat.count_zero = count_reg == '0;

    assign status      = res_status_reg;
    assign entry_count = res_count_reg;
    assign found       = res_found_reg;
    assign days_ahead  = res_day_reg;
    assign out_hour    = res_hour_reg;
    assign out_minute  = res_minute_reg;
    assign out_days    = res_days_reg;
    assign out_enabled = res_enabled_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + 4'd1) || (count_reg == $past(count_reg) - 4'd1))
        else $error("entry count jumped");

    a_fail_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.put_write && status_reg) |=> (count_reg == $past(count_reg)))
        else $error("rejected put changed the table");

endmodule

// ----- dv/weekly_alarm_table_next_match_test.sv -----
// ----------------------------------------------------------------------------
// weekly_alarm_table_next_match_test
// Drives put, remove, read and next-alarm commands into the alarm table and
// checks every result beat against a cycle-free predictor of the table. A
// short directed table covers the edges, then random command traffic keeps
// the table busy under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module weekly_alarm_table_next_match_test;
    import watnm_pkg::*;

    localparam int MAX_ALARMS   = 8;
    localparam int RANDOM_BEATS = 1800;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_PCT     = 38;
    localparam int MAX_REPORTS  = 10;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_BAD = 1'b1;

    typedef struct packed {
        cmd_t                   cmd;
        logic [COUNT_W-1:0]     slot;
        alarm_t                 entry;
        logic [WEEKDAY_W-1:0]   now_wd;
        logic [HOUR_W-1:0]      now_h;
        logic [MINUTE_W-1:0]    now_m;
    } alarm_request_t;

    typedef struct packed {
        logic                   status;
        logic [COUNT_W-1:0]     count;
        logic                   found;
        logic [2:0]             days_ahead;
        logic [HOUR_W-1:0]      hour;
        logic [MINUTE_W-1:0]    minute;
        logic [DAYS_W-1:0]      days;
        logic                   enabled;
    } alarm_reply_t;

    typedef struct {
        alarm_request_t rq;
        bit             known;
        alarm_reply_t   want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            cmd = '0;
    logic [COUNT_W-1:0]    slot = '0;
    logic [HOUR_W-1:0]     entry_hour = '0;
    logic [MINUTE_W-1:0]   entry_minute = '0;
    logic [DAYS_W-1:0]     entry_days = '0;
    logic                  entry_enabled = 1'b0;
    logic [WEEKDAY_W-1:0]  now_weekday = '0;
    logic [HOUR_W-1:0]     now_hour = '0;
    logic [MINUTE_W-1:0]   now_minute = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  status;
    logic [COUNT_W-1:0]    entry_count;
    logic                  found;
    logic [2:0]            days_ahead;
    logic [HOUR_W-1:0]     out_hour;
    logic [MINUTE_W-1:0]   out_minute;
    logic [DAYS_W-1:0]     out_days;
    logic                  out_enabled;

    alarm_t       shadow_alarms [MAX_ALARMS];
    int           shadow_count = 0;
    alarm_reply_t replies_due [$];

    int fails = 0;
    int replies_checked = 0;
    int quiet_cycles = 0;
    int puts = 0, rejects = 0, removes = 0, reads = 0, searches = 0, hits_found = 0;

    weekly_alarm_table_next_match #(.MAX_ALARMS(MAX_ALARMS)) dut (.*);

    always #4 clk = ~clk;

    function automatic alarm_reply_t predict_reply(alarm_request_t rq);
        alarm_reply_t rp;
        int now_key, tkey, key, best, wd;
        bit hit;
        rp = '0;
        rp.status = ST_OK;
        case (rq.cmd)
            CMD_PUT:
            begin
                if (rq.entry.hour > MAX_HOUR || rq.entry.minute > MAX_MINUTE
                    || rq.entry.days[6:0] == '0)
                    rp.status = ST_BAD;
                else if (rq.slot < shadow_count)
                    shadow_alarms[rq.slot] = rq.entry;
                else if (rq.slot == shadow_count && shadow_count < MAX_ALARMS)
                begin
                    shadow_alarms[rq.slot] = rq.entry;
                    shadow_count++;
                end
                else
                    rp.status = ST_BAD;
            end
            CMD_REMOVE:
            begin
                if (rq.slot < shadow_count)
                begin
                    for (int i = rq.slot; i + 1 < shadow_count; i++)
                        shadow_alarms[i] = shadow_alarms[i + 1];
                    shadow_count--;
                end
                else
                    rp.status = ST_BAD;
            end
            CMD_READ:
            begin
                if (rq.slot < shadow_count)
                begin
                    rp.hour    = shadow_alarms[rq.slot].hour;
                    rp.minute  = shadow_alarms[rq.slot].minute;
                    rp.days    = shadow_alarms[rq.slot].days;
                    rp.enabled = shadow_alarms[rq.slot].enabled;
                end
                else
                    rp.status = ST_BAD;
            end
            default:
            begin
                now_key = int'(rq.now_h) * 60 + int'(rq.now_m);
                hit = 1'b0;
                best = 0;
                for (int d = 0; d <= int'(WEEK_DAYS); d++)
                begin
                    wd = (int'(rq.now_wd) + d) % int'(WEEK_DAYS);
                    for (int i = 0; i < shadow_count; i++)
                    begin
                        tkey = int'(shadow_alarms[i].hour) * 60 + int'(shadow_alarms[i].minute);
                        key = d * 1440 + tkey;
                        if (!shadow_alarms[i].enabled || !shadow_alarms[i].days[wd])
                            continue;
                        if (d == 0 && tkey <= now_key)
                            continue;
                        if (!hit || key < best)
                        begin
                            hit = 1'b1;
                            best = key;
                            rp.found = 1'b1;
                            rp.days_ahead = 3'(d);
                            rp.hour = shadow_alarms[i].hour;
                            rp.minute = shadow_alarms[i].minute;
                        end
                    end
                end
            end
        endcase
        rp.count = COUNT_W'(shadow_count);
        return rp;
    endfunction

    function automatic alarm_request_t random_request();
        alarm_request_t rq;
        int roll, put_share, rm_share, pick;
        rq.slot = COUNT_W'($urandom_range(0, 15));
        rq.entry.hour = HOUR_W'($urandom_range(0, 31));
        rq.entry.minute = MINUTE_W'($urandom_range(0, 63));
        rq.entry.days = DAYS_W'($urandom_range(0, 255));
        rq.entry.enabled = 1'($urandom_range(0, 1));
        rq.now_wd = WEEKDAY_W'($urandom_range(0, 7));
        rq.now_h = HOUR_W'($urandom_range(0, 31));
        rq.now_m = MINUTE_W'($urandom_range(0, 63));
        put_share = (shadow_count < 3) ? 55 : 35;
        rm_share = (shadow_count > 5) ? 20 : 10;
        roll = $urandom_range(0, 99);
        pick = (shadow_count > 0) ? $urandom_range(0, shadow_count - 1) : 0;
        if (roll < put_share)
        begin
            rq.cmd = CMD_PUT;
            if ($urandom_range(0, 99) < 85)
                rq.slot = COUNT_W'($urandom_range(0, shadow_count));
            if (shadow_count > 0 && $urandom_range(0, 99) < 25)
            begin
                rq.entry.hour = shadow_alarms[pick].hour;
                rq.entry.minute = shadow_alarms[pick].minute;
            end
            else
            begin
                if ($urandom_range(0, 99) < 90)
                    rq.entry.hour = HOUR_W'($urandom_range(0, 23));
                if ($urandom_range(0, 99) < 90)
                    rq.entry.minute = MINUTE_W'($urandom_range(0, 59));
            end
            if ($urandom_range(0, 99) < 30)
                rq.entry.days = 8'd1 << $urandom_range(0, 7);
            if (rq.entry.days[6:0] == '0 && $urandom_range(0, 99) < 85)
                rq.entry.days[$urandom_range(0, 6)] = 1'b1;
            rq.entry.enabled = ($urandom_range(0, 99) < 80);
        end
        else if (roll < put_share + rm_share + 15)
        begin
            rq.cmd = (roll < put_share + rm_share) ? CMD_REMOVE : CMD_READ;
            if (shadow_count > 0 && $urandom_range(0, 99) < 85)
                rq.slot = COUNT_W'(pick);
        end
        else
        begin
            rq.cmd = CMD_NEXT;
            if ($urandom_range(0, 99) < 90)
                rq.now_wd = WEEKDAY_W'($urandom_range(0, 6));
            roll = $urandom_range(0, 99);
            if (shadow_count > 0 && roll < 40)
            begin
                rq.now_h = shadow_alarms[pick].hour;
                rq.now_m = shadow_alarms[pick].minute;
                if (rq.now_m > 0 && $urandom_range(0, 2) == 0)
                    rq.now_m = rq.now_m - 6'd1;
            end
            else if (roll < 90)
            begin
                rq.now_h = HOUR_W'($urandom_range(0, 23));
                rq.now_m = MINUTE_W'($urandom_range(0, 59));
            end
        end
        return rq;
    endfunction

    function automatic plan_row_t step_row(cmd_t c, int s, int h, int m, int d, int e,
                                           int nw, int nh, int nm);
        plan_row_t r;
        r.rq.cmd = c;
        r.rq.slot = COUNT_W'(s);
        r.rq.entry.hour = HOUR_W'(h);
        r.rq.entry.minute = MINUTE_W'(m);
        r.rq.entry.days = DAYS_W'(d);
        r.rq.entry.enabled = 1'(e);
        r.rq.now_wd = WEEKDAY_W'(nw);
        r.rq.now_h = HOUR_W'(nh);
        r.rq.now_m = MINUTE_W'(nm);
        r.known = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic plan_row_t with_reply(plan_row_t r, logic st, int cnt, alarm_t shown);
        r.known = 1'b1;
        r.want = '0;
        r.want.status = st;
        r.want.count = COUNT_W'(cnt);
        r.want.hour = shown.hour;
        r.want.minute = shown.minute;
        r.want.days = shown.days;
        r.want.enabled = shown.enabled;
        return r;
    endfunction

    function automatic string show(alarm_reply_t r);
        return $sformatf("st=%0d cnt=%0d found=%0d ahead=%0d %0d:%0d days=%h en=%0d",
                         r.status, r.count, r.found, r.days_ahead, r.hour, r.minute,
                         r.days, r.enabled);
    endfunction

    task automatic offer(alarm_request_t rq, bit calm);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cmd <= rq.cmd;
        slot <= rq.slot;
        entry_hour <= rq.entry.hour;
        entry_minute <= rq.entry.minute;
        entry_days <= rq.entry.days;
        entry_enabled <= rq.entry.enabled;
        now_weekday <= rq.now_wd;
        now_hour <= rq.now_h;
        now_minute <= rq.now_m;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic queue_reply(alarm_request_t rq, alarm_reply_t due);
        replies_due.push_back(due);
        case (rq.cmd)
            CMD_PUT:    puts++;
            CMD_REMOVE: removes++;
            CMD_READ:   reads++;
            default:    searches++;
        endcase
        if (due.status == ST_BAD)
            rejects++;
        if (due.found)
            hits_found++;
    endtask

    initial
    begin : stimulus
        plan_row_t      plan [$];
        alarm_request_t rq;
        alarm_reply_t   due;

        plan.push_back(with_reply(step_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0), ST_BAD, 0, '0));
        plan.push_back(with_reply(step_row(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0), ST_BAD, 0, '0));
        plan.push_back(with_reply(step_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 0, 0), ST_OK, 0, '0));
        plan.push_back(with_reply(step_row(CMD_PUT, 1, 8, 0, 8'h7F, 1, 0, 0, 0), ST_BAD, 0, '0));
        plan.push_back(with_reply(step_row(CMD_PUT, 0, 31, 0, 8'h7F, 1, 0, 0, 0), ST_BAD, 0, '0));
        plan.push_back(with_reply(step_row(CMD_PUT, 0, 0, 63, 8'h7F, 1, 0, 0, 0), ST_BAD, 0, '0));
        plan.push_back(with_reply(step_row(CMD_PUT, 0, 9, 0, 8'h80, 1, 0, 0, 0), ST_BAD, 0, '0));
        plan.push_back(with_reply(step_row(CMD_PUT, 0, 23, 59, 8'h7F, 1, 0, 0, 0), ST_OK, 1, '0));
        plan.push_back(step_row(CMD_PUT, 1, 0, 0, 8'h01, 1, 0, 0, 0));
        plan.push_back(step_row(CMD_PUT, 2, 12, 30, 8'hFF, 0, 0, 0, 0));
        plan.push_back(with_reply(step_row(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0), ST_OK, 3,
                                  alarm_t'{5'd23, 6'd59, 8'h7F, 1'b1}));
        plan.push_back(step_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 23, 59));
        plan.push_back(step_row(CMD_NEXT, 0, 0, 0, 0, 0, 0, 23, 58));
        plan.push_back(step_row(CMD_NEXT, 0, 0, 0, 0, 0, 7, 31, 63));
        plan.push_back(step_row(CMD_PUT, 3, 6, 15, 8'h2A, 1, 0, 0, 0));
        plan.push_back(step_row(CMD_PUT, 4, 0, 1, 8'hC0, 1, 0, 0, 0));
        plan.push_back(step_row(CMD_PUT, 5, 23, 0, 8'h10, 1, 0, 0, 0));
        plan.push_back(step_row(CMD_PUT, 6, 12, 30, 8'h08, 1, 0, 0, 0));
        plan.push_back(step_row(CMD_PUT, 7, 7, 45, 8'h7F, 1, 0, 0, 0));
        plan.push_back(with_reply(step_row(CMD_PUT, 8, 1, 1, 8'h01, 1, 0, 0, 0), ST_BAD, 8, '0));
        plan.push_back(step_row(CMD_PUT, 2, 6, 15, 8'h40, 1, 0, 0, 0));
        plan.push_back(step_row(CMD_NEXT, 0, 0, 0, 0, 0, 6, 6, 14));
        plan.push_back(step_row(CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0));
        plan.push_back(with_reply(step_row(CMD_REMOVE, 15, 0, 0, 0, 0, 0, 0, 0), ST_BAD, 7, '0));
        plan.push_back(with_reply(step_row(CMD_READ, 7, 0, 0, 0, 0, 0, 0, 0), ST_BAD, 7, '0));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[k])
        begin
            offer(plan[k].rq, 1'b0);
            due = predict_reply(plan[k].rq);
            if (plan[k].known)
                due = plan[k].want;
            queue_reply(plan[k].rq, due);
        end

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            rq = random_request();
            offer(rq, n >= 1200 && n < 1500);
            queue_reply(rq, predict_reply(rq));
        end
        in_valid <= 1'b0;

        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d puts, %0d removes, %0d reads, %0d next searches (%0d matched)",
                 puts, removes, reads, searches, hits_found);
        $display("%0d commands rejected, %0d result beats checked, %0d mismatches",
                 rejects, replies_checked, fails);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : result_sink
        int cyc;
        cyc = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc == 4000)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                cyc += HOLD_CYCLES;
            end
            else if (cyc > 8000 && cyc < 11000)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : check_replies
        alarm_reply_t got, want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {status, entry_count, found, days_ahead, out_hour, out_minute,
                   out_days, out_enabled};
            if (replies_due.size() == 0)
            begin
                fails++;
                if (fails <= MAX_REPORTS)
                    $display("unexpected result beat: %s", show(got));
            end
            else
            begin
                want = replies_due.pop_front();
                replies_checked++;
                if (got !== want)
                begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("mismatch on result %0d\n  expected %s\n  actual   %s",
                                 replies_checked, show(want), show(got));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("no beat moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, replies_due.size());
            $display("FAILURE");
            $finish;
        end
    end

endmodule
